// ===== rtl/core/wbps_pkg.sv =====
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants of the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package wbps_pkg;

    // Pattern capacity of the configuration registers
    localparam int unsigned REG_CAP = 32;

    localparam int unsigned ADDR_W    = 64;
    localparam int unsigned LENGTH_W  = 6;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_ADDRESS  = 3'd0,
        REG_PATTERN_LEN   = 3'd1,
        REG_PATTERN_0_7   = 3'd2,
        REG_PATTERN_8_15  = 3'd3,
        REG_PATTERN_16_23 = 3'd4,
        REG_PATTERN_24_31 = 3'd5,
        REG_WILDCARD_MASK = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [ADDR_W-1:0]          base_address;
        logic [LENGTH_W-1:0]        pattern_length;
        logic [REG_CAP-1:0][7:0]    pattern_bytes;
        logic [REG_CAP-1:0]         wildcard_mask;
    } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/wbps_cfg.sv =====
// ----------------------------------------------------------------------------
// wbps_cfg
// Configuration register file: base address, pattern length, pattern bytes
// and wildcard mask, written through the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_cfg (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [wbps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [wbps_pkg::CFG_DATA_W-1:0]  cfg_data,
    output wbps_pkg::cfg_t                        cfg_o
);

    wbps_pkg::cfg_t cfg_reg;
    wbps_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg_o     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                wbps_pkg::REG_BASE_ADDRESS: begin
                    cfg_next.base_address = cfg_data;
                end
                wbps_pkg::REG_PATTERN_LEN: begin
                    cfg_next.pattern_length = cfg_data[wbps_pkg::LENGTH_W-1:0];
                end
                wbps_pkg::REG_PATTERN_0_7: begin
                    cfg_next.pattern_bytes[7:0] = cfg_data;
                end
                wbps_pkg::REG_PATTERN_8_15: begin
                    cfg_next.pattern_bytes[15:8] = cfg_data;
                end
                wbps_pkg::REG_PATTERN_16_23: begin
                    cfg_next.pattern_bytes[23:16] = cfg_data;
                end
                wbps_pkg::REG_PATTERN_24_31: begin
                    cfg_next.pattern_bytes[31:24] = cfg_data;
                end
                wbps_pkg::REG_WILDCARD_MASK: begin
                    cfg_next.wildcard_mask = cfg_data[wbps_pkg::REG_CAP-1:0];
                end
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.base_address   <= '0;
            cfg_reg.pattern_length <= wbps_pkg::LENGTH_W'(1);
            cfg_reg.pattern_bytes  <= '0;
            cfg_reg.wildcard_mask  <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/wbps_match.sv =====
// ----------------------------------------------------------------------------
// wbps_match
// Parallel window compare: aligns the newest n window bytes to the pattern
// and checks every position against its pattern byte or wildcard bit.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_match #(
    parameter int unsigned NCMP = 32
) (
    input  wire logic [NCMP-1:0][7:0]               window_i,
    input  wire logic [NCMP-1:0][7:0]               pattern_i,
    input  wire logic [NCMP-1:0]                    wild_i,
    input  wire logic [$clog2(NCMP+1)-1:0]          n_i,
    output logic                                    hit_o
);

    localparam int unsigned LEN_W = $clog2(NCMP + 1);
    localparam int unsigned IDX_W = (NCMP > 1) ? $clog2(NCMP) : 1;

    logic [NCMP-1:0] pos_ok;

    // Pattern byte j lines up with the byte received n-1-j beats ago
    for (genvar j = 0; j < NCMP; j++) begin : g_pos
        logic [LEN_W-1:0] tap;
        assign tap        = n_i - LEN_W'(j + 1);
        assign pos_ok[j]  = (LEN_W'(j) >= n_i) || wild_i[j] ||
                            (window_i[tap[IDX_W-1:0]] == pattern_i[j]);
    end

    assign hit_o = &pos_ok;

endmodule

`default_nettype wire

// ===== rtl/core/wbps_scan.sv =====
// ----------------------------------------------------------------------------
// wbps_scan
// Scan state and result register: byte window, saturating byte count,
// match-reported flag, and the registered found/address result.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_scan #(
    parameter int unsigned NCMP       = 32,
    parameter int unsigned COUNT_BITS = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire wbps_pkg::cfg_t                  cfg_i,
    input  wire logic                            item_valid_i,
    input  wire logic [7:0]                      item_data_i,
    input  wire logic                            item_last_i,
    output logic                                 item_ready_o,
    output logic                                 res_valid_o,
    input  wire logic                            res_ready_i,
    output logic                                 res_found_o,
    output logic [wbps_pkg::ADDR_W-1:0]          res_address_o
);

    localparam int unsigned LEN_W = $clog2(NCMP + 1);

    logic [NCMP-1:0][7:0]          window_reg, window_next, window_shift;
    logic [COUNT_BITS-1:0]         count_reg, count_next, count_inc;
    logic                          reported_reg, reported_next;
    logic                          res_valid_reg, res_valid_next;
    logic                          res_found_reg, res_found_next;
    logic [wbps_pkg::ADDR_W-1:0]   res_address_reg, res_address_next;

    logic                          advance;
    logic [LEN_W-1:0]              n_eff;
    logic                          window_hit;
    logic                          hit;
    logic                          produce;
    logic [COUNT_BITS-1:0]         offset;

    assign item_ready_o  = !res_valid_reg || res_ready_i;
    assign advance       = item_valid_i && item_ready_o;

    assign res_valid_o   = res_valid_reg;
    assign res_found_o   = res_found_reg;
    assign res_address_o = res_address_reg;

    // Clamp the configured length to the compare width
    assign n_eff = (cfg_i.pattern_length > wbps_pkg::LENGTH_W'(NCMP)) ?
                   LEN_W'(NCMP) : LEN_W'(cfg_i.pattern_length);

    assign window_shift = {window_reg[NCMP-2:0], item_data_i};
    assign count_inc    = (count_reg == {COUNT_BITS{1'b1}}) ?
                          count_reg : count_reg + 1'b1;
    assign offset       = count_inc - COUNT_BITS'(n_eff);

    wbps_match #(
        .NCMP (NCMP)
    ) u_match (
        .window_i  (window_shift),
        .pattern_i (cfg_i.pattern_bytes[NCMP-1:0]),
        .wild_i    (cfg_i.wildcard_mask[NCMP-1:0]),
        .n_i       (n_eff),
        .hit_o     (window_hit)
    );

    assign hit     = !reported_reg && (n_eff != '0) &&
                     (count_inc >= COUNT_BITS'(n_eff)) && window_hit;
    assign produce = !reported_reg && (hit || item_last_i);

    always_comb begin
        window_next      = window_reg;
        count_next       = count_reg;
        reported_next    = reported_reg;
        res_valid_next   = res_valid_reg && !res_ready_i;
        res_found_next   = res_found_reg;
        res_address_next = res_address_reg;
        if (advance) begin
            if (item_last_i) begin
                // end of region: restart the scan
                count_next    = '0;
                reported_next = 1'b0;
            end else if (!reported_reg) begin
                window_next   = window_shift;
                count_next    = count_inc;
                reported_next = hit;
            end
            if (produce) begin
                res_valid_next   = 1'b1;
                res_found_next   = hit;
                res_address_next = hit ?
                    cfg_i.base_address + wbps_pkg::ADDR_W'(offset) : '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            reported_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            reported_reg  <= reported_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Window bytes are only read once the count covers them
    always_ff @(posedge aclk) begin
        window_reg      <= window_next;
        res_found_reg   <= res_found_next;
        res_address_reg <= res_address_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/wildcard_byte_pattern_scan.sv =====
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan
// Streams a memory region one byte per beat and reports the address of the
// first match of a wildcard byte pattern, or a not-found beat at region end.
// ----------------------------------------------------------------------------
// An accepted input beat passes the input register, then the result register.
// Throughput: one byte per cycle unless a result beat waits on m_tready; the
//   window compare sits in a single stage between the input and result registers.
// Reset: aresetn clears the configuration to its reset values and empties the
//   scan state; no clearing pass is needed.
`default_nettype none

module wildcard_byte_pattern_scan #(
    parameter int unsigned MAX_PATTERN = 32,
    parameter int unsigned COUNT_BITS  = 32
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // input byte stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,   // [7:0] data_byte
    input  wire logic                             s_tlast,   // last_byte
    // result stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [wbps_pkg::ADDR_W-1:0]           m_tdata,   // [63:0] match_address
    output logic [0:0]                            m_tuser,   // [0] found
    // configuration write channel
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [wbps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [wbps_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int unsigned NCMP = (MAX_PATTERN < wbps_pkg::REG_CAP) ?
                                   MAX_PATTERN : wbps_pkg::REG_CAP;

    wbps_pkg::cfg_t cfg;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_data_reg;
    logic       in_last_reg;
    logic       item_ready;
    logic       res_found;

    wbps_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_o     (cfg)
    );

    // Input register: take a beat whenever the slot is empty or draining
    assign s_tready      = !in_valid_reg || item_ready;
    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    wbps_scan #(
        .NCMP       (NCMP),
        .COUNT_BITS (COUNT_BITS)
    ) u_scan (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_i         (cfg),
        .item_valid_i  (in_valid_reg),
        .item_data_i   (in_data_reg),
        .item_last_i   (in_last_reg),
        .item_ready_o  (item_ready),
        .res_valid_o   (m_tvalid),
        .res_ready_i   (m_tready),
        .res_found_o   (res_found),
        .res_address_o (m_tdata)
    );

    assign m_tuser = res_found;

endmodule

`default_nettype wire
